/* hw/rtl/hfr_pkg.sv */
// Shared types, constants and decode helpers for the hex frame receiver.
`timescale 1ns / 1ps
package hfr_pkg;

	localparam int BUFFER_BYTES = 64;
	localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
	localparam int ADDR_W = $clog2(BUFFER_BYTES);

	localparam logic [7:0] SOH_CHAR = 8'h01;
	localparam logic [7:0] STX_CHAR = 8'h02;

	// frame length limits: shortest legal frame, shortest frame with a message code, shortest frame with a payload pair
	localparam int LEN_MIN = 6;
	localparam int LEN_MSG = 7;
	localparam int LEN_PAIR = 9;
	localparam int SIZE_OVERHEAD = 4;
	localparam int PAY_START = 4;

	typedef enum logic [2:0] {
		STAT_WAIT    = 3'd0,
		STAT_PENDING = 3'd1,
		STAT_BAD     = 3'd2,
		STAT_BAD_SUM = 3'd3,
		STAT_OK      = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic       sub;
	} alu_req_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// upper-case hex digit to value, anything else decodes as zero
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'h00;
			if (c >= 8'h30 && c <= 8'h39) begin
				d = c - 8'h30;
			end else if (c >= 8'h41 && c <= 8'h46) begin
				d = c - 8'h37;
			end
			return d[3:0];
		end
	endfunction

endpackage

/* hw/rtl/hfr_alu.sv */
// Shared 8-bit add/subtract unit used for the running sum, checksum and address steps.
`timescale 1ns / 1ps
module hfr_alu (
	input  hfr_pkg::alu_req_t req,
	output logic [7:0]        y
);

	always_comb begin
		if (req.sub) begin
			y = req.a - req.b;
		end else begin
			y = req.a + req.b;
		end
	end

endmodule

/* hw/rtl/hfr_mem.sv */
// Frame byte store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module hfr_mem (
	input  logic              clk,
	input  hfr_pkg::mem_req_t req,
	output logic [7:0]        rdata
);

	logic [7:0] mem_q [hfr_pkg::BUFFER_BYTES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem_q[req.raddr];
		end
	end

endmodule

/* hw/rtl/hex_frame_receiver_core.sv */
// Top level of the hex frame receiver: byte sequencer, checksum steps and output register.
// Each received byte is one transaction on the input and yields one status transaction,
// or on a good frame a status transaction followed by one transaction per decoded payload
// byte. A byte goes through accept, update and emit; emit holds while the output is stalled.
// On the closing STX the shared 8-bit adder runs three more steps to form the checksum,
// then the header result goes out and each payload byte is read as two stored digits
// through the single read port of the 64-byte frame store. The input is stalled until the
// last result of the current byte has been loaded into the output register.
`timescale 1ns / 1ps
module hex_frame_receiver_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [7:0] msg_code,
	output logic [7:0] data_byte,
	output logic       has_data,
	output logic       last
);

	localparam int FW = hfr_pkg::FILL_W;
	localparam int AW = hfr_pkg::ADDR_W;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_STEP  = 10'b00_0000_0010,
		S_EMIT  = 10'b00_0000_0100,
		S_CHK_A = 10'b00_0000_1000,
		S_CHK_B = 10'b00_0001_0000,
		S_CHK_C = 10'b00_0010_0000,
		S_HDR   = 10'b00_0100_0000,
		S_P_HI  = 10'b00_1000_0000,
		S_P_LO  = 10'b01_0000_0000,
		S_P_OUT = 10'b10_0000_0000
	} state_t;

	state_t           state_q, state_d;
	logic [FW-1:0]    fill_q;
	logic [7:0]       sum_q;
	logic [7:0]       byte_q;
	logic [7:0]       last1_q, last2_q;
	logic [3:0]       size_hi_q, size_lo_q;
	logic [7:0]       msg_q;
	logic [7:0]       acc_q;
	logic [FW-1:0]    p_q;
	logic [3:0]       hi_nib_q;
	hfr_pkg::status_t res_q;

	logic             out_valid_q;
	hfr_pkg::status_t status_q;
	logic [7:0]       msg_code_q, data_byte_q;
	logic             has_data_q, last_q;

	hfr_pkg::alu_req_t alu_req;
	logic [7:0]        alu_y;
	hfr_pkg::mem_req_t mem_req;
	logic [7:0]        mem_rdata;

	logic       slot_free;
	logic       out_load;
	logic       in_take;
	logic [7:0] want;
	logic [7:0] size_val;
	logic       fill_lo;
	logic       pair_last;

	hfr_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	hfr_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	assign slot_free = !out_valid_q || !out_stall;
	assign out_load  = slot_free &&
	                   (state_q == S_EMIT || state_q == S_HDR || state_q == S_P_OUT);
	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign want      = {hfr_pkg::nibble_of(last2_q), hfr_pkg::nibble_of(last1_q)};
	assign size_val  = {size_hi_q, size_lo_q};
	assign fill_lo   = (fill_q == FW'(1)) || (fill_q == FW'(2));
	assign pair_last = (9'(p_q) + 9'(hfr_pkg::PAY_START + 3)) > 9'(fill_q);

	always_comb begin
		alu_req.a   = sum_q;
		alu_req.b   = byte_q;
		alu_req.sub = 1'b0;
		unique case (state_q)
			S_CHK_A: begin
				alu_req.a   = sum_q;
				alu_req.b   = last2_q;
				alu_req.sub = 1'b1;
			end
			S_CHK_B: begin
				alu_req.a   = acc_q;
				alu_req.b   = last1_q;
				alu_req.sub = 1'b1;
			end
			S_CHK_C: begin
				alu_req.a   = acc_q;
				alu_req.b   = hfr_pkg::STX_CHAR;
				alu_req.sub = 1'b1;
			end
			S_P_OUT: begin
				alu_req.a   = 8'(p_q);
				alu_req.b   = 8'd2;
				alu_req.sub = 1'b0;
			end
			default: begin
				alu_req.a   = sum_q;
				alu_req.b   = byte_q;
				alu_req.sub = 1'b0;
			end
		endcase
	end

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = fill_q[AW-1:0];
		mem_req.wdata = byte_q;
		mem_req.re    = 1'b0;
		mem_req.raddr = p_q[AW-1:0];
		if (state_q == S_STEP) begin
			if (fill_q == '0) begin
				mem_req.we = (byte_q == hfr_pkg::SOH_CHAR);
			end else if (fill_lo) begin
				if (byte_q == hfr_pkg::SOH_CHAR) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = '0;
				end else begin
					mem_req.we = (byte_q != hfr_pkg::STX_CHAR);
				end
			end else if (fill_q < FW'(hfr_pkg::BUFFER_BYTES)) begin
				mem_req.we = 1'b1;
				// a new SOH restarts the frame at the head of the store
				if (byte_q == hfr_pkg::SOH_CHAR) begin
					mem_req.waddr = '0;
				end
			end
		end else if (state_q == S_P_HI) begin
			mem_req.re = 1'b1;
		end else if (state_q == S_P_LO) begin
			mem_req.re    = 1'b1;
			mem_req.raddr = {p_q[AW-1:1], 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_STEP: begin
					if (fill_q == '0) begin
						if (byte_q == hfr_pkg::SOH_CHAR) begin
							fill_q <= FW'(1);
						end
					end else if (fill_lo) begin
						if (byte_q == hfr_pkg::SOH_CHAR) begin
							fill_q <= FW'(1);
							sum_q  <= '0;
						end else if (byte_q == hfr_pkg::STX_CHAR) begin
							fill_q <= '0;
							sum_q  <= '0;
						end else begin
							fill_q <= fill_q + FW'(1);
						end
					end else if (fill_q < FW'(hfr_pkg::BUFFER_BYTES)) begin
						if (byte_q == hfr_pkg::SOH_CHAR) begin
							fill_q <= FW'(1);
							sum_q  <= '0;
						end else begin
							fill_q <= fill_q + FW'(1);
							sum_q  <= alu_y;
						end
					end else begin
						// store full: drop the byte and start over
						fill_q <= '0;
						sum_q  <= '0;
					end
				end
				S_CHK_A: begin
					if (fill_q < FW'(hfr_pkg::LEN_MIN) ||
					    9'(size_val) + 9'(hfr_pkg::SIZE_OVERHEAD) != 9'(fill_q)) begin
						fill_q <= '0;
						sum_q  <= '0;
					end
				end
				S_CHK_C: begin
					if (alu_y != want) begin
						fill_q <= '0;
						sum_q  <= '0;
					end
				end
				S_HDR: begin
					if (slot_free) begin
						if (fill_q < FW'(hfr_pkg::LEN_PAIR)) begin
							fill_q <= '0;
							sum_q  <= '0;
						end
					end
				end
				S_P_OUT: begin
					if (slot_free) begin
						if (pair_last) begin
							fill_q <= '0;
							sum_q  <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_q <= rx_byte;
		end
		unique case (state_q)
			S_STEP: begin
				if (fill_q == '0) begin
					res_q <= (byte_q == hfr_pkg::SOH_CHAR) ? hfr_pkg::STAT_PENDING
					                                       : hfr_pkg::STAT_WAIT;
				end else if (fill_lo) begin
					res_q <= (byte_q == hfr_pkg::STX_CHAR) ? hfr_pkg::STAT_BAD
					                                       : hfr_pkg::STAT_PENDING;
				end else if (fill_q < FW'(hfr_pkg::BUFFER_BYTES)) begin
					res_q <= hfr_pkg::STAT_PENDING;
				end else begin
					res_q <= hfr_pkg::STAT_WAIT;
				end
				if (byte_q != hfr_pkg::STX_CHAR) begin
					last2_q <= last1_q;
					last1_q <= byte_q;
				end
				if (fill_q == FW'(1)) begin
					size_hi_q <= hfr_pkg::nibble_of(byte_q);
				end
				if (fill_q == FW'(2)) begin
					size_lo_q <= hfr_pkg::nibble_of(byte_q);
				end
				if (fill_q == FW'(3)) begin
					msg_q <= byte_q;
				end
			end
			S_CHK_A: begin
				acc_q <= alu_y;
				res_q <= hfr_pkg::STAT_BAD;
			end
			S_CHK_B: begin
				acc_q <= alu_y;
			end
			S_CHK_C: begin
				res_q <= hfr_pkg::STAT_BAD_SUM;
			end
			S_HDR: begin
				p_q <= FW'(hfr_pkg::PAY_START);
			end
			S_P_LO: begin
				hi_nib_q <= hfr_pkg::nibble_of(mem_rdata);
			end
			S_P_OUT: begin
				if (slot_free) begin
					p_q <= FW'(alu_y);
				end
			end
			default: begin
			end
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (state_q == S_EMIT) begin
				status_q    <= res_q;
				msg_code_q  <= '0;
				data_byte_q <= '0;
				has_data_q  <= 1'b0;
				last_q      <= 1'b1;
			end else if (state_q == S_HDR) begin
				status_q    <= hfr_pkg::STAT_OK;
				msg_code_q  <= (fill_q >= FW'(hfr_pkg::LEN_MSG)) ? msg_q : 8'h00;
				data_byte_q <= '0;
				has_data_q  <= 1'b0;
				last_q      <= (fill_q < FW'(hfr_pkg::LEN_PAIR));
			end else if (state_q == S_P_OUT) begin
				status_q    <= hfr_pkg::STAT_OK;
				data_byte_q <= {hi_nib_q, hfr_pkg::nibble_of(mem_rdata)};
				has_data_q  <= 1'b1;
				last_q      <= pair_last;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_take) begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				if (byte_q == hfr_pkg::STX_CHAR && !fill_lo && fill_q != '0 &&
				    fill_q < FW'(hfr_pkg::BUFFER_BYTES)) begin
					state_d = S_CHK_A;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			S_CHK_A: begin
				if (fill_q < FW'(hfr_pkg::LEN_MIN) ||
				    9'(size_val) + 9'(hfr_pkg::SIZE_OVERHEAD) != 9'(fill_q)) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_CHK_B;
				end
			end
			S_CHK_B: state_d = S_CHK_C;
			S_CHK_C: begin
				state_d = (alu_y != want) ? S_EMIT : S_HDR;
			end
			S_HDR: begin
				if (slot_free) begin
					state_d = (fill_q < FW'(hfr_pkg::LEN_PAIR)) ? S_IDLE : S_P_HI;
				end
			end
			S_P_HI: state_d = S_P_LO;
			S_P_LO: state_d = S_P_OUT;
			S_P_OUT: begin
				if (slot_free) begin
					state_d = pair_last ? S_IDLE : S_P_HI;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign msg_code  = msg_code_q;
	assign data_byte = data_byte_q;
	assign has_data  = has_data_q;
	assign last      = last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(hfr_pkg::BUFFER_BYTES))
		else $error("fill count beyond store size");

	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && has_data_q |-> status_q == hfr_pkg::STAT_OK)
		else $error("payload byte outside a good frame");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("input taken again before the byte was processed");

	a_read_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_P_HI |-> 9'(p_q) + 9'd1 < 9'(fill_q))
		else $error("payload read past the stored frame");

	a_idle_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && $past(state_q) == S_P_OUT |-> fill_q == '0)
		else $error("frame state not cleared after payload");

endmodule

/* verif/frame_check_pkg.sv */
// Byte-level predictor and result scoreboard for the hex frame receiver testbench.
`timescale 1ns / 1ps
package frame_check_pkg;
	import hfr_pkg::*;

	typedef struct {
		status_t    status;
		logic [7:0] msg;
		logic [7:0] data;
		logic       has;
		logic       last;
	} rx_result_t;

	// upper-case hex only; everything else counts as zero
	function automatic logic [3:0] digit_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c[3:0];
		if (c >= "A" && c <= "F") return c[3:0] + 4'd9;
		return 4'd0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
	endfunction

	function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
		return {digit_of(hi), digit_of(lo)};
	endfunction

	class frame_checker;
		logic [7:0]  frame_bytes[BUFFER_BYTES];
		int unsigned fill;
		logic [7:0]  body_sum;
		rx_result_t  predicted_results[$];
		int unsigned errors;

		function new();
			fill = 0;
			body_sum = 8'h00;
			errors = 0;
		endfunction

		function void restart();
			fill = 0;
			body_sum = 8'h00;
		endfunction

		function void keep_byte(input logic [7:0] b);
			if (fill < BUFFER_BYTES) begin
				// sum covers everything after the size field
				if (fill >= PAY_START - 1) body_sum += b;
				frame_bytes[fill] = b;
				fill++;
			end
		endfunction

		function void add_result(input status_t st, input logic [7:0] msg,
				input logic [7:0] data, input logic has, input logic lst);
			rx_result_t r;
			r.status = st;
			r.msg = msg;
			r.data = data;
			r.has = has;
			r.last = lst;
			predicted_results.push_back(r);
		endfunction

		function void close_frame();
			int unsigned len;
			int unsigned npairs;
			logic [7:0]  want;
			logic [7:0]  got;
			logic [7:0]  msg;
			len = fill;
			if (len < LEN_MIN) begin
				restart();
				add_result(STAT_BAD, 8'h00, 8'h00, 1'b0, 1'b1);
				return;
			end
			if (pair_value(frame_bytes[1], frame_bytes[2]) != 8'(len - SIZE_OVERHEAD)) begin
				restart();
				add_result(STAT_BAD, 8'h00, 8'h00, 1'b0, 1'b1);
				return;
			end
			want = pair_value(frame_bytes[len-3], frame_bytes[len-2]);
			got = body_sum - frame_bytes[len-3] - frame_bytes[len-2] - frame_bytes[len-1];
			if (got != want) begin
				restart();
				add_result(STAT_BAD_SUM, 8'h00, 8'h00, 1'b0, 1'b1);
				return;
			end
			msg = (len >= LEN_MSG) ? frame_bytes[3] : 8'h00;
			npairs = (len >= LEN_MSG) ? (len - LEN_MSG) / 2 : 0;
			add_result(STAT_OK, msg, 8'h00, 1'b0, npairs == 0);
			for (int unsigned i = 0; i < npairs; i++) begin
				add_result(STAT_OK, msg,
					pair_value(frame_bytes[PAY_START+2*i], frame_bytes[PAY_START+2*i+1]),
					1'b1, i + 1 == npairs);
			end
			restart();
		endfunction

		function void predict_byte(input logic [7:0] b);
			if (fill == 0 && b == SOH_CHAR) begin
				keep_byte(b);
				add_result(STAT_PENDING, 8'h00, 8'h00, 1'b0, 1'b1);
			end else if (fill == 1 || fill == 2) begin
				if (b == STX_CHAR) begin
					restart();
					add_result(STAT_BAD, 8'h00, 8'h00, 1'b0, 1'b1);
				end else begin
					if (b == SOH_CHAR) restart();
					keep_byte(b);
					add_result(STAT_PENDING, 8'h00, 8'h00, 1'b0, 1'b1);
				end
			end else if (fill > 2 && fill < BUFFER_BYTES) begin
				keep_byte(b);
				if (b == STX_CHAR) begin
					close_frame();
				end else begin
					// resync on a fresh SOH
					if (b == SOH_CHAR) begin
						restart();
						keep_byte(b);
					end
					add_result(STAT_PENDING, 8'h00, 8'h00, 1'b0, 1'b1);
				end
			end else begin
				// idle noise, or the byte after a full store: drop it
				restart();
				add_result(STAT_WAIT, 8'h00, 8'h00, 1'b0, 1'b1);
			end
		endfunction

		function int unsigned pending();
			return predicted_results.size();
		endfunction

		function void check_result(input logic [2:0] st, input logic [7:0] msg,
				input logic [7:0] data, input logic has, input logic lst);
			rx_result_t w;
			if (predicted_results.size() == 0) begin
				$error("unpredicted result: status %0d msg_code %02h data_byte %02h", st, msg,
					data);
				errors++;
				return;
			end
			w = predicted_results.pop_front();
			if (st !== 3'(w.status)) begin
				$error("status: expected %0d, got %0d", w.status, st);
				errors++;
			end
			if (msg !== w.msg) begin
				$error("msg_code: expected %02h, got %02h", w.msg, msg);
				errors++;
			end
			if (data !== w.data) begin
				$error("data_byte: expected %02h, got %02h", w.data, data);
				errors++;
			end
			if (has !== w.has) begin
				$error("has_data: expected %0b, got %0b", w.has, has);
				errors++;
			end
			if (lst !== w.last) begin
				$error("last: expected %0b, got %0b", w.last, lst);
				errors++;
			end
		endfunction
	endclass

endpackage

/* verif/tb_top.sv */
// Top of the hex frame receiver testbench: clock, reset, byte driver, stall and monitors.
`timescale 1ns / 1ps
module tb_top;
	import hfr_pkg::*;
	import frame_check_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int PHASE_ITEMS = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] status;
	logic [7:0] msg_code;
	logic [7:0] data_byte;
	logic       has_data;
	logic       last;

	int          stall_pct = 0;
	int          send_idle_pct = 0;
	int          hold_reqs = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int unsigned items_sent = 0;
	logic [7:0]  frame_q[$];
	logic [7:0]  body_q[$];

	frame_checker chk = new();

	hex_frame_receiver_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.msg_code  (msg_code),
		.data_byte (data_byte),
		.has_data  (has_data),
		.last      (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver side: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				chk.check_result(status, msg_code, data_byte, has_data, last);
			if (in_valid && !in_stall)
				chk.predict_byte(rx_byte);
		end
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	function automatic logic [7:0] body_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (c == SOH_CHAR || c == STX_CHAR) c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// append a well-formed frame around body_q; without a message body_q must be empty
	function automatic void queue_frame(input logic has_msg, input logic [7:0] msg);
		logic [7:0] size_v;
		logic [7:0] sum_v;
		size_v = has_msg ? 8'(LEN_MSG + body_q.size() - SIZE_OVERHEAD)
			: 8'(LEN_MIN - SIZE_OVERHEAD);
		sum_v = has_msg ? msg : 8'h00;
		foreach (body_q[i]) sum_v += body_q[i];
		frame_q.push_back(SOH_CHAR);
		frame_q.push_back(hex_char(size_v[7:4]));
		frame_q.push_back(hex_char(size_v[3:0]));
		if (has_msg) frame_q.push_back(msg);
		foreach (body_q[i]) frame_q.push_back(body_q[i]);
		frame_q.push_back(hex_char(sum_v[7:4]));
		frame_q.push_back(hex_char(sum_v[3:0]));
		frame_q.push_back(STX_CHAR);
	endfunction

	function automatic void random_sequence();
		int   kind;
		int   npc;
		int   pos;
		int   k;
		logic has_msg;
		logic hex_only;
		kind = $urandom_range(0, 99);
		if (kind >= 83 && kind < 88) begin
			// too short, or STX inside the size field
			frame_q.push_back(SOH_CHAR);
			k = $urandom_range(0, 3);
			repeat (k) frame_q.push_back(hex_char(4'($urandom_range(0, 15))));
			frame_q.push_back(STX_CHAR);
		end else if (kind >= 88 && kind < 96) begin
			k = $urandom_range(1, 5);
			repeat (k) frame_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			has_msg = ($urandom_range(0, 9) != 0);
			npc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, BUFFER_BYTES - LEN_MSG)
				: $urandom_range(0, 12);
			hex_only = ($urandom_range(0, 3) != 0);
			body_q.delete();
			if (has_msg) begin
				for (int i = 0; i < npc; i++)
					body_q.push_back(hex_only ? hex_char(4'($urandom_range(0, 15))) : body_char());
			end
			queue_frame(has_msg, body_char());
			if (kind >= 55 && kind < 65) begin
				frame_q[2] = hex_char(digit_of(frame_q[2]) + 4'd1);
			end else if (kind >= 65 && kind < 75) begin
				pos = frame_q.size() - 2;
				frame_q[pos] = hex_char(digit_of(frame_q[pos]) + 4'd1);
			end else if (kind >= 75 && kind < 83) begin
				pos = $urandom_range(1, frame_q.size() - 1);
				frame_q.insert(pos, SOH_CHAR);
			end else if (kind >= 96) begin
				// junk in a size or checksum position
				k = $urandom_range(0, 3);
				pos = (k < 2) ? k + 1 : frame_q.size() - 5 + k;
				frame_q[pos] = body_char();
			end
		end
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_queued();
		foreach (frame_q[i]) send_byte(frame_q[i]);
		items_sent += frame_q.size();
		frame_q.delete();
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chk.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int busy_pct);
		send_idle_pct = idle_pct;
		stall_pct <= busy_pct;
		items_sent = 0;
		while (items_sent < PHASE_ITEMS) begin
			random_sequence();
			send_queued();
		end
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle noise, STX in size field, short frame
		frame_q = '{8'hFF, 8'h00, SOH_CHAR, STX_CHAR, SOH_CHAR, "0", "1", STX_CHAR};
		// six-byte frame with zero checksum
		body_q.delete();
		queue_frame(1'b0, 8'h00);
		// SOH restart in the size field, then odd payload with a non-hex digit
		frame_q.push_back(SOH_CHAR);
		frame_q.push_back("0");
		body_q = '{"F", "F", "G", "0", "A"};
		queue_frame(1'b1, "Z");
		// checksum off by one digit
		body_q.delete();
		queue_frame(1'b1, "A");
		frame_q[frame_q.size()-2] = hex_char(digit_of(frame_q[frame_q.size()-2]) + 4'd1);
		send_queued();
		wait_drained();

		// long hold-off while the longest frame and a store overflow go in
		hold_reqs <= hold_reqs + 1;
		body_q.delete();
		repeat (BUFFER_BYTES - LEN_MSG) body_q.push_back(hex_char(4'($urandom_range(0, 15))));
		queue_frame(1'b1, body_char());
		frame_q.push_back(SOH_CHAR);
		repeat (BUFFER_BYTES - 1) frame_q.push_back(body_char());
		frame_q.push_back(8'($urandom_range(0, 255)));
		send_queued();
		run_phase(0, 0);

		run_phase(60, 0);
		run_phase(0, 60);
		run_phase(31, 31);

		if (chk.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
